### sv/decimal_int_parser_core_assert.svh
// Assertion macros shared by the decimal integer parser RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef DECIMAL_INT_PARSER_CORE_ASSERT_SVH
`define DECIMAL_INT_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off while reset is active.
`define DIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("decimal_int_parser_core: check failed");

// Next-cycle implication, held off while reset is active.
`define DIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("decimal_int_parser_core: check failed");

`else

`define DIP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DIP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/dip_pkg.sv
// Shared types and constants for the decimal integer parser.
// No dependencies; imported by every module of the block.
package dip_pkg;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Magnitude limits: largest value that may still take *10, and the
	// largest digit that may follow it.
	localparam int unsigned MAG_W = 63;
	localparam logic [MAG_W-1:0] MAG_DIV_TEN = 63'd922337203685477580;
	localparam logic [3:0] DIGIT_LIM = 4'd7;

	// Queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_byte;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic               is_number;
		logic signed [63:0] number;
	} result_item_t;

	typedef enum logic [1:0] {
		CLS_SPACE,
		CLS_SIGN,
		CLS_DIGIT,
		CLS_OTHER
	} char_class_t;

	// Classified item as held in the queue
	typedef struct packed {
		char_class_t kind;
		logic        minus;
		logic [3:0]  digit;
		logic        has_byte;
		logic        last;
	} cls_item_t;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_SIGN   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_TRAIL  = 3'd3,
		PH_BAD    = 3'd4
	} phase_t;

endpackage

### sv/dip_queue.sv
// Short FIFO of classified items between front and back.
// Depends on dip_pkg and the assertion macro header.
`include "decimal_int_parser_core_assert.svh"

module dip_queue
	import dip_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output cls_item_t head_item
);

	cls_item_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DIP_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QDEPTH))
	`DIP_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, count_q != '0)
	`DIP_ASSERT_NXT(a_drain_step, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

### sv/dip_front.sv
// Front end: takes byte transactions and classifies each byte.
// Depends on dip_pkg.
module dip_front
	import dip_pkg::*;
(
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_data,
	input  logic       q_full,
	output logic       push,
	output cls_item_t  push_item
);

	logic [7:0] c;
	logic       is_space;
	logic       is_sign;
	logic       is_digit;

	assign c = byte_data.char_byte;

	always_comb begin
		is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
		is_sign  = (c == CH_MINUS) || (c == CH_PLUS);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

		push_item.kind     = is_space ? CLS_SPACE :
		                     is_sign  ? CLS_SIGN  :
		                     is_digit ? CLS_DIGIT : CLS_OTHER;
		push_item.minus    = (c == CH_MINUS);
		push_item.digit    = 4'(c - CH_ZERO);
		push_item.has_byte = byte_data.has_byte;
		push_item.last     = byte_data.last;
	end

	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;

endmodule

### sv/dip_back.sv
// Back end: parse state machine, magnitude accumulator and result register.
// Depends on dip_pkg and the assertion macro header.
`include "decimal_int_parser_core_assert.svh"

module dip_back
	import dip_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  cls_item_t    q_item,
	output logic         q_pop,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_data
);

	phase_t           phase_q, phase_d, phase_step;
	logic [MAG_W-1:0] mag_q, mag_d, mag_acc;
	logic             neg_q, neg_d;
	logic             acc_en, set_neg, ovf, take, finish;

	logic             res_valid_q;
	logic             res_ok_q;
	logic             res_neg_q;
	logic [MAG_W-1:0] res_mag_q;

	function automatic logic phase_d_done(input phase_t ph);
		return (ph == PH_DIGITS) || (ph == PH_TRAIL);
	endfunction

	// Only a last item needs the result slot
	assign q_pop  = q_valid && (!q_item.last || !res_valid_q || !result_stall);
	assign take   = q_pop && q_item.has_byte;
	assign finish = q_pop && q_item.last;

	// mag*10 + d; only kept when the overflow test passes
	assign mag_acc = (mag_q << 3) + (mag_q << 1) + MAG_W'(q_item.digit);
	assign ovf     = (mag_q > MAG_DIV_TEN) ||
	                 ((mag_q == MAG_DIV_TEN) && (q_item.digit > DIGIT_LIM));

	// Phase reached by one byte
	always_comb begin
		phase_step = phase_q;
		acc_en     = 1'b0;
		set_neg    = 1'b0;
		unique case (phase_q)
			PH_LEAD: begin
				unique case (q_item.kind)
					CLS_SPACE: phase_step = PH_LEAD;
					CLS_SIGN: begin
						phase_step = PH_SIGN;
						set_neg    = 1'b1;
					end
					CLS_DIGIT: acc_en = 1'b1;
					default:   phase_step = PH_BAD;
				endcase
			end
			PH_SIGN: begin
				if (q_item.kind == CLS_DIGIT) begin
					acc_en = 1'b1;
				end else begin
					phase_step = PH_BAD;
				end
			end
			PH_DIGITS: begin
				unique case (q_item.kind)
					CLS_SPACE: phase_step = PH_TRAIL;
					CLS_DIGIT: acc_en = 1'b1;
					default:   phase_step = PH_BAD;
				endcase
			end
			PH_TRAIL: begin
				phase_step = (q_item.kind == CLS_SPACE) ? PH_TRAIL : PH_BAD;
			end
			default: phase_step = PH_BAD;
		endcase
		if (acc_en) begin
			phase_step = ovf ? PH_BAD : PH_DIGITS;
		end
	end

	// Next state
	always_comb begin
		priority if (finish) begin
			phase_d = PH_LEAD;
		end else if (take) begin
			phase_d = phase_step;
		end else begin
			phase_d = phase_q;
		end
	end

	// Datapath updates
	always_comb begin
		mag_d = mag_q;
		neg_d = neg_q;
		if (take && acc_en && !ovf) begin
			mag_d = mag_acc;
		end
		if (take && set_neg) begin
			neg_d = q_item.minus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (finish) begin
				mag_q       <= '0;
				neg_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				mag_q <= mag_d;
				neg_q <= neg_d;
				if (res_valid_q && !result_stall) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_ok_q  <= (phase_d_done(take ? phase_step : phase_q));
			res_neg_q <= neg_d;
			res_mag_q <= mag_d;
		end
	end

	// Sign applied on the way out
	assign result_valid          = res_valid_q;
	assign result_data.is_number = res_ok_q;
	assign result_data.number    = !res_ok_q  ? 64'sd0 :
	                               res_neg_q ? -$signed({1'b0, res_mag_q}) :
	                                           $signed({1'b0, res_mag_q});

	`DIP_ASSERT_NXT(a_reset_after_last, clk, arst_n, finish,
		phase_q == PH_LEAD && mag_q == '0 && !neg_q)
	`DIP_ASSERT_NXT(a_result_follows, clk, arst_n, finish, res_valid_q)
	`DIP_ASSERT_NOW(a_lead_clean, clk, arst_n, phase_q == PH_LEAD, mag_q == '0 && !neg_q)

endmodule

### sv/decimal_int_parser_core.sv
// Top level of the decimal integer parser: byte stream in, one result per string.
// Depends on dip_pkg, dip_front, dip_queue and dip_back.
//
// Feed a string one byte per transaction; the transaction with last set
// ends it and one result transaction follows, giving is_number and the
// signed 64-bit value (zero when is_number is clear). Leading and trailing
// space, tab, LF and CR are skipped; an optional sign and one or more
// decimal digits must stand between them, and a magnitude above 2^63-1
// (so also -2^63) is rejected. A transaction with has_byte clear carries
// no byte and only matters when last is set. The block takes one byte
// transaction per cycle while the queue is not full: the back end's step
// is one 63-bit shift-add for the multiply by ten plus the overflow compare
// against (2^63-1)/10, both combinational. A byte accepted is written into
// the queue and processed once it reaches the queue head, and its result,
// when last is set, is offered from the following cycle. A four-entry queue
// between front and back absorbs result-side stalls; only a last byte waits
// for the result register to free up, so a stall on results eventually
// stalls bytes once the queue is full. After each result the parser is back
// in its reset state, ready for the next string without a pause.
module decimal_int_parser_core
	import dip_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  byte_item_t   byte_data,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_data
);

	logic      q_full;
	logic      q_push;
	cls_item_t q_push_item;
	logic      q_pop;
	logic      q_head_valid;
	cls_item_t q_head_item;

	// Front: classify the byte and push it straight into the queue
	dip_front u_front (
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_full     (q_full),
		.push       (q_push),
		.push_item  (q_push_item)
	);

	// Decouples the byte side from result back-pressure
	dip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head_item)
	);

	// Back: state machine, accumulator and result register
	dip_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_head_valid),
		.q_item       (q_head_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
